// ----- sv/qslerp_pkg.sv -----
// Shared constants, types and the arctangent table for the quaternion slerp unit.
// Used by every cell module and by the top level; depends on nothing else.
package qslerp_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int TABLE_LEN           = 30;

    // Blend factor and threshold register formats.
    localparam int BLEND_W    = 16;
    localparam int BLEND_FRAC = 15;
    localparam logic [BLEND_W-1:0] BLEND_ONE = 16'd32768;
    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] THRESH_RESET = 16'd1;

    // Q.30 angle and trigonometry formats.
    localparam int CW      = 36;  // CORDIC x and y
    localparam int ZW      = 34;  // CORDIC angle accumulator
    localparam int ANG_W   = 32;  // unsigned angle in [0, pi]
    localparam int ROOT_W  = 31;  // magnitude in [0, 1], sine of the angle, weights
    localparam int SQ_W    = 62;  // square root radicand
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 31;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint CORDIC_GAIN = 64'sd652032874;

    typedef enum logic {
        CORDIC_VECTOR,
        CORDIC_ROTATE
    } t_cordic_mode;

    // atan(2^-i) in Q.30, truncated except the last three entries, which are rounded.
    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:  v = ZW'(32'h3243F6A8);
            1:  v = ZW'(32'h1DAC6705);
            2:  v = ZW'(32'h0FADBAFC);
            3:  v = ZW'(32'h07F56EA6);
            4:  v = ZW'(32'h03FEAB76);
            5:  v = ZW'(32'h01FFD55B);
            6:  v = ZW'(32'h00FFFAAA);
            7:  v = ZW'(32'h007FFF55);
            8:  v = ZW'(32'h003FFFEA);
            9:  v = ZW'(32'h001FFFFD);
            10: v = ZW'(32'h000FFFFF);
            11: v = ZW'(32'h0007FFFF);
            12: v = ZW'(32'h0003FFFF);
            13: v = ZW'(32'h0001FFFF);
            14: v = ZW'(32'h0000FFFF);
            15: v = ZW'(32'h00007FFF);
            16: v = ZW'(32'h00003FFF);
            17: v = ZW'(32'h00001FFF);
            18: v = ZW'(32'h00000FFF);
            19: v = ZW'(32'h000007FF);
            20: v = ZW'(32'h000003FF);
            21: v = ZW'(32'h000001FF);
            22: v = ZW'(32'h000000FF);
            23: v = ZW'(32'h0000007F);
            24: v = ZW'(32'h0000003F);
            25: v = ZW'(32'h0000001F);
            26: v = ZW'(32'h0000000F);
            27: v = ZW'(32'h00000008);
            28: v = ZW'(32'h00000004);
            29: v = ZW'(32'h00000002);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/quaternion_slerp_unit.sv -----
// Quaternion slerp unit: fully pipelined, one transaction taken per cycle unless stalled.
// The square root, both CORDIC chains and the two weight dividers are rows of
// single-step cells.
// Throughput is one item per cycle; an output stall freezes the whole pipeline.
// Reset (synchronous, active low) empties the pipeline and sets the threshold to 1.
module quaternion_slerp_unit #(
    parameter int COMPONENT_WIDTH = qslerp_pkg::COMPONENT_WIDTH_DEF,
    parameter int TRIG_ITERATIONS = qslerp_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [COMPONENT_WIDTH-1:0]     i_first_x,
    input  logic signed [COMPONENT_WIDTH-1:0]     i_first_y,
    input  logic signed [COMPONENT_WIDTH-1:0]     i_first_z,
    input  logic signed [COMPONENT_WIDTH-1:0]     i_first_w,
    input  logic signed [COMPONENT_WIDTH-1:0]     i_second_x,
    input  logic signed [COMPONENT_WIDTH-1:0]     i_second_y,
    input  logic signed [COMPONENT_WIDTH-1:0]     i_second_z,
    input  logic signed [COMPONENT_WIDTH-1:0]     i_second_w,
    input  logic [qslerp_pkg::BLEND_W-1:0]        i_blend,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [COMPONENT_WIDTH-1:0]     o_out_x,
    output logic signed [COMPONENT_WIDTH-1:0]     o_out_y,
    output logic signed [COMPONENT_WIDTH-1:0]     o_out_z,
    output logic signed [COMPONENT_WIDTH-1:0]     o_out_w,
    output logic                                  o_linear_used,
    output logic                                  o_saturated,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [qslerp_pkg::CFG_W-1:0]          i_cfg_data
);
    import qslerp_pkg::*;

    localparam int W   = COMPONENT_WIDTH;
    localparam int F   = W - 1;
    localparam int NIT = (TRIG_ITERATIONS < TABLE_LEN) ? TRIG_ITERATIONS : TABLE_LEN;
    localparam int DW  = W + 3;
    localparam int SHL = (F <= 30) ? 30 - F : 0;
    localparam int SHR = (F > 30) ? F - 30 : 0;
    localparam int CQW = DW + SHL + 1;
    localparam int PW  = ROOT_W + 1 + W;

    localparam int ST_IN    = 0;
    localparam int ST_DOT   = 1;
    localparam int ST_SQ    = 2;
    localparam int ST_SQRT0 = 3;
    localparam int ST_AT0   = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_ANG   = ST_AT0 + NIT;
    localparam int ST_SCL   = ST_ANG + 1;
    localparam int ST_SIN0  = ST_SCL + 1;
    localparam int ST_WP    = ST_SIN0 + NIT;
    localparam int ST_DIV0  = ST_WP + 1;
    localparam int ST_PROD  = ST_DIV0 + DIV_STEPS;
    localparam int ST_OUT   = ST_PROD + 1;
    localparam int NST      = ST_OUT + 1;

    localparam logic signed [2*W:0]   RND_DOT = (2*W+1)'(1) <<< (F - 1);
    localparam logic signed [DW:0]    ONE_F   = (DW+1)'(1) <<< F;
    localparam logic signed [CQW-1:0] CQ_ONE  = CQW'(Q30_ONE);
    localparam logic [SQ_W-1:0]       SQ_ONE  = SQ_W'(1) << 60;
    localparam logic signed [ZW-1:0]  PI_Z    = ZW'(PI_Q30);
    localparam logic [ANG_W-1:0]      PI_A    = ANG_W'(PI_Q30);
    localparam logic [ANG_W-1:0]      HPI_A   = ANG_W'(HALF_PI_Q30);
    localparam logic signed [PW:0]    RND_LIN = (PW+1)'(1) <<< (BLEND_FRAC - 1);
    localparam logic signed [PW:0]    RND_SLP = (PW+1)'(1) <<< 29;
    localparam logic signed [PW:0]    OUT_HI  = ((PW+1)'(1) <<< F) - (PW+1)'(1);
    localparam logic signed [PW:0]    OUT_LO  = -((PW+1)'(1) <<< F);

    typedef struct packed {
        logic [3:0][W-1:0]     a;
        logic [3:0][W-1:0]     b;
        logic [BLEND_W-1:0]    t;
        logic                  lin;
        logic                  cneg;
        logic [ROOT_W-1:0]     cabs;
        logic [ROOT_W-1:0]     d;
        logic [1:0]            wneg;
        logic [1:0]            wbig;
    } t_side;

    logic en;
    logic r_vld [NST];
    t_side r_sb [ST_PROD+1];
    t_side n_sb [ST_PROD+1];
    logic [CFG_W-1:0] r_thr;

    // Stage-local registers.
    logic signed [2*W-1:0] r_pd [4];
    logic [SQ_W-1:0]       r_csq;
    logic [ANG_W-1:0]      r_ang;
    logic [ANG_W-1:0]      r_sa [2];
    logic [ROOT_W-1:0]     r_rem0 [2];
    logic                  r_bit0 [2];
    logic signed [PW-1:0]  r_pm [4][2];
    logic signed [W-1:0]   r_res [4];
    logic                  r_lin, r_sat;

    // Stage combinational values.
    logic signed [2*W:0]   rnd;
    logic signed [DW-1:0]  dot;
    logic signed [DW:0]    diff;
    logic [DW:0]           absd;
    logic signed [CQW-1:0] cq, mag;
    logic [ROOT_W-1:0]     cabs;
    logic [ROOT_W-1:0]     dsq;
    logic signed [ZW-1:0]  angz;
    logic [ANG_W-1:0]      angc;
    logic [ANG_W+BLEND_W-1:0] sp [2];
    logic [ANG_W-1:0]      sfold [2];
    logic                  wn [2];
    logic                  wb [2];
    logic [ROOT_W-1:0]     wgt [2];
    logic [ROOT_W-1:0]     m0, m1;
    logic signed [PW:0]    sum [4];
    logic signed [PW:0]    shf [4];
    logic signed [W-1:0]   res [4];
    logic                  clip_any;
    logic [BLEND_W-1:0]    t_in;
    t_side                 sb_in;

    // Cell chains.
    logic [SQ_W-1:0]      sq_rem  [SQRT_STEPS+1];
    logic [SQ_W-1:0]      sq_root [SQRT_STEPS+1];
    logic signed [CW-1:0] at_x [NIT+1];
    logic signed [CW-1:0] at_y [NIT+1];
    logic signed [ZW-1:0] at_z [NIT+1];
    logic signed [CW-1:0] sn_x [2][NIT+1];
    logic signed [CW-1:0] sn_y [2][NIT+1];
    logic signed [ZW-1:0] sn_z [2][NIT+1];
    logic [ROOT_W-1:0]    dv_rem [2][DIV_STEPS+1];
    logic [ROOT_W-1:0]    dv_quo [2][DIV_STEPS+1];

    assign en          = !(r_vld[ST_OUT] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < NST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Input stage: blend clip and the four dot product terms.
    always_comb begin
        t_in = (i_blend > BLEND_ONE) ? BLEND_ONE : i_blend;
        sb_in      = '0;
        sb_in.a[0] = i_first_x;
        sb_in.a[1] = i_first_y;
        sb_in.a[2] = i_first_z;
        sb_in.a[3] = i_first_w;
        sb_in.b[0] = i_second_x;
        sb_in.b[1] = i_second_y;
        sb_in.b[2] = i_second_z;
        sb_in.b[3] = i_second_w;
        sb_in.t    = t_in;
    end

    // Dot product, threshold test and conversion of the cosine to Q.30.
    always_comb begin
        dot = '0;
        rnd = '0;
        for (int i = 0; i < 4; i++) begin
            rnd = ($signed({r_pd[i][2*W-1], r_pd[i]}) + RND_DOT) >>> F;
            dot = dot + DW'(rnd);
        end
        diff = $signed({dot[DW-1], dot}) - ONE_F;
        absd = diff[DW] ? unsigned'(-diff) : unsigned'(diff);
        cq   = (CQW'(dot) <<< SHL) >>> SHR;
        mag  = cq[CQW-1] ? -cq : cq;
        cabs = (mag > CQ_ONE) ? ROOT_W'(Q30_ONE) : mag[ROOT_W-1:0];
    end

    assign dsq = sq_root[SQRT_STEPS][ROOT_W-1:0];

    // Angle from the vectoring chain, folded for a negative cosine and clamped.
    always_comb begin
        angz = r_sb[ST_ANG-1].cneg ? PI_Z - at_z[NIT] : at_z[NIT];
        if (angz[ZW-1]) begin
            angc = '0;
        end else if (angz > PI_Z) begin
            angc = PI_A;
        end else begin
            angc = angz[ANG_W-1:0];
        end
        sp[0] = (ANG_W+BLEND_W)'(r_ang) * (ANG_W+BLEND_W)'(BLEND_ONE - r_sb[ST_SCL-1].t);
        sp[1] = (ANG_W+BLEND_W)'(r_ang) * (ANG_W+BLEND_W)'(r_sb[ST_SCL-1].t);
        for (int l = 0; l < 2; l++) begin
            sfold[l] = (r_sa[l] > HPI_A) ? PI_A - r_sa[l] : r_sa[l];
        end
    end

    // Weight preparation: a negative sine forces zero, a quotient of two or
    // more forces the maximum weight, otherwise the divider runs.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            wn[l] = sn_y[l][NIT][CW-1];
            wb[l] = !wn[l] &&
                    (sn_y[l][NIT] >= $signed(CW'({r_sb[ST_WP-1].d, 1'b0})));
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_sb[ST_PROD-1].wneg[l]) begin
                wgt[l] = '0;
            end else if (r_sb[ST_PROD-1].wbig[l]) begin
                wgt[l] = '1;
            end else begin
                wgt[l] = dv_quo[l][DIV_STEPS];
            end
        end
        m0 = r_sb[ST_PROD-1].lin ? ROOT_W'(BLEND_ONE - r_sb[ST_PROD-1].t) : wgt[0];
        m1 = r_sb[ST_PROD-1].lin ? ROOT_W'(r_sb[ST_PROD-1].t) : wgt[1];
    end

    // Final blend, rounding and clipping; the same multipliers serve both paths.
    always_comb begin
        clip_any = 1'b0;
        for (int i = 0; i < 4; i++) begin
            sum[i] = $signed({r_pm[i][0][PW-1], r_pm[i][0]})
                   + $signed({r_pm[i][1][PW-1], r_pm[i][1]})
                   + (r_sb[ST_PROD].lin ? RND_LIN : RND_SLP);
            shf[i] = r_sb[ST_PROD].lin ? (sum[i] >>> BLEND_FRAC) : (sum[i] >>> 30);
            if (shf[i] > OUT_HI) begin
                res[i]   = W'(OUT_HI);
                clip_any = 1'b1;
            end else if (shf[i] < OUT_LO) begin
                res[i]   = W'(OUT_LO);
                clip_any = 1'b1;
            end else begin
                res[i] = W'(shf[i]);
            end
        end
    end

    // Side information that travels with each item.
    always_comb begin
        n_sb[0] = sb_in;
        for (int k = 1; k <= ST_PROD; k++) n_sb[k] = r_sb[k-1];
        n_sb[ST_DOT].lin  = (absd < (DW+1)'(r_thr));
        n_sb[ST_DOT].cneg = cq[CQW-1];
        n_sb[ST_DOT].cabs = cabs;
        // A zero sine means the two rotations coincide or oppose: blend linearly.
        n_sb[ST_AT0].lin  = r_sb[ST_AT0-1].lin || (dsq == '0);
        n_sb[ST_AT0].d    = dsq;
        n_sb[ST_WP].wneg  = {wn[1], wn[0]};
        n_sb[ST_WP].wbig  = {wb[1], wb[0]};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= ST_PROD; k++) r_sb[k] <= n_sb[k];
            for (int i = 0; i < 4; i++) r_pd[i] <= $signed(sb_in.a[i]) * $signed(sb_in.b[i]);
            r_csq    <= SQ_W'(r_sb[ST_DOT].cabs) * SQ_W'(r_sb[ST_DOT].cabs);
            r_ang    <= angc;
            r_sa[0]  <= ANG_W'(sp[0] >> BLEND_FRAC);
            r_sa[1]  <= ANG_W'(sp[1] >> BLEND_FRAC);
            for (int l = 0; l < 2; l++) begin
                r_rem0[l] <= (wn[l] || wb[l]) ? '0 : sn_y[l][NIT][ROOT_W:1];
                r_bit0[l] <= sn_y[l][NIT][0] && !(wn[l] || wb[l]);
            end
            for (int i = 0; i < 4; i++) begin
                r_pm[i][0] <= $signed({1'b0, m0}) * $signed(r_sb[ST_PROD-1].a[i]);
                r_pm[i][1] <= $signed({1'b0, m1}) * $signed(r_sb[ST_PROD-1].b[i]);
            end
            for (int i = 0; i < 4; i++) r_res[i] <= res[i];
            r_lin <= r_sb[ST_PROD].lin;
            r_sat <= clip_any || (!r_sb[ST_PROD].lin &&
                     ((r_sb[ST_PROD].wneg != 2'b00) || (r_sb[ST_PROD].wbig != 2'b00)));
        end
    end

    // Square root of one minus the squared cosine.
    assign sq_rem[0]  = SQ_ONE - r_csq;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        qslerp_sqrt_cell #(.IDX(k)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (sq_rem[k]),
            .i_root (sq_root[k]),
            .o_rem  (sq_rem[k+1]),
            .o_root (sq_root[k+1])
        );
    end

    // Angle by vectoring on (|cos|, sin).
    assign at_x[0] = CW'({1'b0, r_sb[ST_AT0-1].cabs});
    assign at_y[0] = CW'({1'b0, dsq});
    assign at_z[0] = '0;

    for (genvar k = 0; k < NIT; k++) begin : g_atan
        qslerp_cordic_cell #(.IDX(k), .MODE(CORDIC_VECTOR)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (at_x[k]),
            .i_y   (at_y[k]),
            .i_z   (at_z[k]),
            .o_x   (at_x[k+1]),
            .o_y   (at_y[k+1]),
            .o_z   (at_z[k+1])
        );
    end

    // Two sine lanes, then two divider lanes, one per weight.
    for (genvar l = 0; l < 2; l++) begin : g_lane
        assign sn_x[l][0] = CW'(CORDIC_GAIN);
        assign sn_y[l][0] = '0;
        assign sn_z[l][0] = $signed(ZW'(sfold[l]));

        for (genvar k = 0; k < NIT; k++) begin : g_sin
            qslerp_cordic_cell #(.IDX(k), .MODE(CORDIC_ROTATE)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_x   (sn_x[l][k]),
                .i_y   (sn_y[l][k]),
                .i_z   (sn_z[l][k]),
                .o_x   (sn_x[l][k+1]),
                .o_y   (sn_y[l][k+1]),
                .o_z   (sn_z[l][k+1])
            );
        end

        assign dv_rem[l][0] = r_rem0[l];
        assign dv_quo[l][0] = '0;

        for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
            qslerp_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rem (dv_rem[l][k]),
                .i_bit ((k == 0) ? r_bit0[l] : 1'b0),
                .i_den (r_sb[ST_DIV0+k-1].d),
                .i_quo (dv_quo[l][k]),
                .o_rem (dv_rem[l][k+1]),
                .o_quo (dv_quo[l][k+1])
            );
        end
    end

    assign o_out_valid   = r_vld[ST_OUT];
    assign o_out_x       = r_res[0];
    assign o_out_y       = r_res[1];
    assign o_out_z       = r_res[2];
    assign o_out_w       = r_res[3];
    assign o_linear_used = r_lin;
    assign o_saturated   = r_sat;

`ifndef ASSERT_OFF
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_OUT] && i_out_stall) |-> o_in_stall)
        else $error("input taken while the result register is blocked");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[ST_IN])
        else $error("accepted transaction did not enter the pipeline");

    a_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[ST_PROD]) |=> o_out_valid)
        else $error("finished transaction did not reach the output register");
`endif

endmodule

// ----- sv/qslerp_sqrt_cell.sv -----
// One step of the pipelined integer square root: settles one root bit.
// Depends on qslerp_pkg.
module qslerp_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [qslerp_pkg::SQ_W-1:0]   i_rem,
    input  logic [qslerp_pkg::SQ_W-1:0]   i_root,
    output logic [qslerp_pkg::SQ_W-1:0]   o_rem,
    output logic [qslerp_pkg::SQ_W-1:0]   o_root
);
    import qslerp_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - IDX));

    logic [SQ_W-1:0] r_rem, r_root, n_rem, n_root, trial;

    always_comb begin
        trial = i_root + BIT;
        if (i_rem >= trial) begin
            n_rem  = i_rem - trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ----- sv/qslerp_cordic_cell.sv -----
// One CORDIC micro-rotation, vectoring or rotation mode, registered.
// Depends on qslerp_pkg for widths and the arctangent table.
module qslerp_cordic_cell #(
    parameter int                       IDX  = 0,
    parameter qslerp_pkg::t_cordic_mode MODE = qslerp_pkg::CORDIC_VECTOR
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [qslerp_pkg::CW-1:0]   i_x,
    input  logic signed [qslerp_pkg::CW-1:0]   i_y,
    input  logic signed [qslerp_pkg::ZW-1:0]   i_z,
    output logic signed [qslerp_pkg::CW-1:0]   o_x,
    output logic signed [qslerp_pkg::CW-1:0]   o_y,
    output logic signed [qslerp_pkg::ZW-1:0]   o_z
);
    import qslerp_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_entry(IDX);

    logic signed [CW-1:0] r_x, r_y, n_x, n_y, xs, ys;
    logic signed [ZW-1:0] r_z, n_z;
    logic                 pos;

    always_comb begin
        // Vectoring drives y toward zero, rotation drives z toward zero.
        unique case (MODE)
            CORDIC_VECTOR: pos = i_y[CW-1];
            CORDIC_ROTATE: pos = !i_z[ZW-1];
        endcase
        xs = i_x >>> IDX;
        ys = i_y >>> IDX;
        if (pos) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ----- sv/qslerp_div_cell.sv -----
// One restoring division step: produces one quotient bit of a weight.
// Depends on qslerp_pkg.
module qslerp_div_cell (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [qslerp_pkg::ROOT_W-1:0]   i_rem,
    input  logic                            i_bit,
    input  logic [qslerp_pkg::ROOT_W-1:0]   i_den,
    input  logic [qslerp_pkg::ROOT_W-1:0]   i_quo,
    output logic [qslerp_pkg::ROOT_W-1:0]   o_rem,
    output logic [qslerp_pkg::ROOT_W-1:0]   o_quo
);
    import qslerp_pkg::*;

    logic [ROOT_W:0]   sh, den_x;
    logic [ROOT_W-1:0] r_rem, r_quo, n_rem, n_quo;
    logic              ge;

    always_comb begin
        sh    = {i_rem, i_bit};
        den_x = {1'b0, i_den};
        ge    = (sh >= den_x);
        // The partial remainder stays below the divisor, so it fits again.
        n_rem = ge ? ROOT_W'(sh - den_x) : ROOT_W'(sh);
        n_quo = {i_quo[ROOT_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule
